[sv/ole_pkg.sv]
`timescale 1ns / 1ps

package ole_pkg;

  // List geometry
  localparam int CAPACITY = 16;
  localparam int IdxW     = $clog2(CAPACITY);
  localparam int CntW     = $clog2(CAPACITY + 1);

  // Beat field widths
  localparam int CmdW     = 3;
  localparam int DataW    = 32;
  localparam int PosW     = 5;
  localparam int StatusW  = 2;
  localparam int CountW   = 5;

  // Width for position versus count compares
  localparam int CmpW     = (CntW > PosW) ? CntW : PosW;

  // Command codes
  localparam logic [CmdW-1:0] CmdPushFront = 3'd0;
  localparam logic [CmdW-1:0] CmdPushBack  = 3'd1;
  localparam logic [CmdW-1:0] CmdRead      = 3'd2;
  localparam logic [CmdW-1:0] CmdDelete    = 3'd3;
  localparam logic [CmdW-1:0] CmdClear     = 3'd4;

  // Status codes
  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StFull   = 2'd1;
  localparam logic [StatusW-1:0] StBadPos = 2'd2;

  typedef struct packed {
    logic [CmdW-1:0]         command;
    logic signed [DataW-1:0] value_in;
    logic [PosW-1:0]         position;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0]      status;
    logic signed [DataW-1:0] value_out;
    logic [CountW-1:0]       count;
  } rsp_t;

endpackage

[sv/ole_cmd_if.sv]
`timescale 1ns / 1ps

interface ole_cmd_if import ole_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         command;
  logic signed [DataW-1:0] value_in;
  logic [PosW-1:0]         position;

  modport source (output valid, output command, output value_in, output position,
                  input ready);
  modport sink   (input valid, input command, input value_in, input position,
                  output ready);
endinterface

[sv/ole_rsp_if.sv]
`timescale 1ns / 1ps

interface ole_rsp_if import ole_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [DataW-1:0] value_out;
  logic [CountW-1:0]       count;

  modport source (output valid, output status, output value_out, output count,
                  input ready);
  modport sink   (input valid, input status, input value_out, input count,
                  output ready);
endinterface

[sv/ole_store.sv]
`timescale 1ns / 1ps

module ole_store import ole_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  logic [DataW-1:0] ent_q [CAPACITY];
  logic [DataW-1:0] ent_d [CAPACITY];
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  cnt_d;
  logic [CmpW-1:0]  pos_ext;
  logic [CmpW-1:0]  cnt_ext;
  logic [IdxW-1:0]  idx;
  logic             full;
  logic             pos_bad;
  logic [StatusW-1:0] status;
  logic [DataW-1:0]   value;

  // Decode position against the current fill
  assign pos_ext = CmpW'(req_i.position);
  assign cnt_ext = CmpW'(cnt_q);
  assign idx     = IdxW'(pos_ext - CmpW'(1));
  assign full    = (cnt_q >= CntW'(CAPACITY));
  assign pos_bad = (pos_ext == '0) || (pos_ext > cnt_ext);

  // Apply one command: shift entries in parallel where the command needs it, update fill
  always_comb begin
    ent_d  = ent_q;
    cnt_d  = cnt_q;
    status = StOk;
    value  = '0;
    case (req_i.command)
      CmdPushFront: begin
        if (full) begin
          status = StFull;
        end else begin
          ent_d[0] = req_i.value_in;
          for (int i = 1; i < CAPACITY; i++) begin
            ent_d[i] = ent_q[i-1];
          end
          cnt_d = cnt_q + CntW'(1);
        end
      end
      CmdPushBack: begin
        if (full) begin
          status = StFull;
        end else begin
          ent_d[IdxW'(cnt_q)] = req_i.value_in;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      CmdRead: begin
        if (pos_bad) begin
          status = StBadPos;
        end else begin
          value = ent_q[idx];
        end
      end
      CmdDelete: begin
        if (pos_bad) begin
          status = StBadPos;
        end else begin
          value = ent_q[idx];
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (IdxW'(i) >= idx) begin
              ent_d[i] = ent_q[i+1];
            end
          end
          cnt_d = cnt_q - CntW'(1);
        end
      end
      CmdClear: begin
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.status    = status;
  assign rsp_o.value_out = value;
  assign rsp_o.count     = CountW'(cnt_d);

  // Hold the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the entries; no reset, only filled slots are ever read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ent_q <= ent_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("fill count above capacity");

  a_full_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (rsp_o.status == StFull) |=> cnt_q == $past(cnt_q))
    else $error("rejected push changed the fill count");

  a_err_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (rsp_o.status != StOk) |-> rsp_o.value_out == '0)
    else $error("error result carries a value");

  a_bad_pos_keeps_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && (rsp_o.status == StBadPos) |=> cnt_q == $past(cnt_q))
    else $error("bad position changed the fill count");

endmodule

[sv/ordered_list_engine_core.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake     Payload
// cmd_i    in   valid/ready   command, value_in, position
// rsp_o    out  valid/ready   status, value_out, count
//
// One command beat accepted per cycle while the result side is not stalled; its
// result beat passes the input register, then the result register, before it
// is valid on rsp_o.
// The whole list shifts in parallel, so each command sees the list left by
// the previous one with no bubble.
// Reset clears the fill count and both valid flags; entries are not reset.
// A stalled result holds the result register, and the input register keeps
// accepting only while it can drain.

module ordered_list_engine_core import ole_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  ole_cmd_if.sink   cmd_i,
  ole_rsp_if.source rsp_o
);

  req_t in_q;
  logic in_valid_q;
  rsp_t out_q;
  logic out_valid_q;
  rsp_t exec_rsp;
  logic advance;

  // Move the held command into the result register when it can take it
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;

  ole_store u_store (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (advance),
    .req_i (in_q),
    .rsp_o (exec_rsp)
  );

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  // Capture the command beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_q.command  <= cmd_i.command;
      in_q.value_in <= cmd_i.value_in;
      in_q.position <= cmd_i.position;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Capture the result beat
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= exec_rsp;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_q.status;
  assign rsp_o.value_out = out_q.value_out;
  assign rsp_o.count     = out_q.count;

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("executed command left no result");

  a_in_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && (in_q == $past(in_q)))
    else $error("held command lost before execution");

  a_no_exec_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !advance)
    else $error("execution without a held command");

endmodule
